### hdl/bfsc_pkg.sv
// shared types and codes for the best-fit size cache
package bfsc_pkg;

  localparam int SIZE_W = 48;
  localparam int ID_W   = 32;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FIT    = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic              full_res;
    logic [ID_W-1:0]   result_id;
    logic [SIZE_W-1:0] result_size;
  } res_t;

endpackage

### hdl/bfsc_mem.sv
// entry store: one write port, one registered read port
module bfsc_mem #(
  parameter int ENTRIES = 32,
  parameter int IW      = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  bfsc_pkg::entry_t wdata,
  input  logic             re,
  input  logic [IW-1:0]    raddr,
  output bfsc_pkg::entry_t rdata
);
  import bfsc_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/bfsc_ctrl.sv
// sequencer: walks the sorted store from the smallest entry, shifting as it goes
module bfsc_ctrl #(
  parameter int ENTRIES = 32,
  parameter int IW      = 5,
  parameter int CW      = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [bfsc_pkg::SIZE_W-1:0] in_item_size,
  input  logic [bfsc_pkg::ID_W-1:0]   in_object_id,
  output logic                       res_vld,
  output bfsc_pkg::res_t             res,
  input  logic                       out_free,
  output logic                       mem_we,
  output logic [IW-1:0]              mem_waddr,
  output bfsc_pkg::entry_t           mem_wdata,
  output logic                       mem_re,
  output logic [IW-1:0]              mem_raddr,
  input  bfsc_pkg::entry_t           mem_rdata
);
  import bfsc_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_FIT_CHK  = 3'd3;
  localparam logic [2:0] S_FIT      = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  entry_t            carry_r, carry_nxt;
  logic              carry_vld_r, carry_vld_nxt;
  res_t              res_r, res_nxt;

  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] idx_p1;
  logic [IW-1:0] idx_m1;
  logic          accept;
  logic          full;
  entry_t        new_entry;

  assign cnt_m1    = count_r - CW'(1);
  assign idx_p1    = idx_r + IW'(1);
  assign idx_m1    = idx_r - IW'(1);
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (count_r == CW'(ENTRIES));
  assign new_entry = '{size: size_r, id: id_r};
  assign res_vld   = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    size_nxt      = size_r;
    id_nxt        = id_r;
    carry_nxt     = carry_r;
    carry_vld_nxt = carry_vld_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_p1;
    mem_wdata     = new_entry;
    mem_re        = 1'b0;
    mem_raddr     = idx_m1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          size_nxt = in_item_size;
          id_nxt   = in_object_id;
          res_nxt  = '0;
          if (in_kind == KIND_INSERT) begin
            if (full) begin
              res_nxt.full_res = 1'b1;
              state_nxt        = S_DONE;
            end else if (count_r == '0) begin
              state_nxt = S_INS_LAST;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = cnt_m1[IW-1:0];
              idx_nxt   = cnt_m1[IW-1:0];
              state_nxt = S_INS;
            end
          end else begin
            if (count_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_nxt = S_FIT_CHK;
            end
          end
        end
      end
      S_INS: begin
        mem_we = 1'b1;
        if (mem_rdata.size < size_r) begin
          // move the smaller entry up one place
          mem_wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_INS_LAST;
          end else begin
            mem_re  = 1'b1;
            idx_nxt = idx_m1;
          end
        end else begin
          count_nxt     = count_r + CW'(1);
          res_nxt.found = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_INS_LAST: begin
        mem_we        = 1'b1;
        mem_waddr     = '0;
        count_nxt     = count_r + CW'(1);
        res_nxt.found = 1'b1;
        state_nxt     = S_DONE;
      end
      S_FIT_CHK: begin
        // largest entry too small means a miss and no change
        if (mem_rdata.size < size_r) begin
          state_nxt = S_DONE;
        end else begin
          mem_re        = 1'b1;
          mem_raddr     = cnt_m1[IW-1:0];
          idx_nxt       = cnt_m1[IW-1:0];
          carry_vld_nxt = 1'b0;
          state_nxt     = S_FIT;
        end
      end
      S_FIT: begin
        mem_we    = carry_vld_r;
        mem_waddr = idx_r;
        mem_wdata = carry_r;
        if (mem_rdata.size >= size_r) begin
          res_nxt.found       = 1'b1;
          res_nxt.result_id   = mem_rdata.id;
          res_nxt.result_size = mem_rdata.size;
          count_nxt           = cnt_m1;
          state_nxt           = S_DONE;
        end else begin
          carry_nxt     = mem_rdata;
          carry_vld_nxt = 1'b1;
          mem_re        = 1'b1;
          idx_nxt       = idx_m1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      carry_vld_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      carry_vld_r <= carry_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    size_r  <= size_nxt;
    id_r    <= id_nxt;
    carry_r <= carry_nxt;
    res_r   <= res_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r) || count_r == $past(count_r) + CW'(1) ||
              count_r + CW'(1) == $past(count_r)))
    else $error("entry count moved by more than one");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same entry in one cycle");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_INSERT && full) |=>
      (state_r == S_DONE && res_r.full_res && !res_r.found && count_r == $past(count_r)))
    else $error("insert into full store not dropped");

  a_count_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_r.found) |-> (count_r == $past(count_r)))
    else $error("count changed on a miss or drop");
`endif

endmodule

### hdl/best_fit_size_cache_unit.sv
// top level of the best-fit size cache: sequencer, entry store and result register
// Holds up to ENTRIES objects (id, size) sorted largest first in one single-port-read
// memory. One item is worked at a time: the sequencer walks the store one entry per
// cycle from the smallest end through the memory's single read port, shifting entries
// as it goes; a fit whose largest entry is too small, a full-store insert and an
// empty-store fit answer without the walk. The result sits in an output register, so
// the next item is taken while a result still waits on out_stall.
module best_fit_size_cache_unit #(
  parameter int ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [bfsc_pkg::SIZE_W-1:0] in_item_size,
  input  logic [bfsc_pkg::ID_W-1:0]   in_object_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic                        out_full_res,
  output logic [bfsc_pkg::ID_W-1:0]   out_result_id,
  output logic [bfsc_pkg::SIZE_W-1:0] out_result_size
);
  import bfsc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          res_vld;
  res_t          res;
  logic          out_free;
  logic          out_valid_r;
  res_t          out_res_r;

  assign out_free = !out_valid_r || !out_stall;

  bfsc_ctrl #(
    .ENTRIES(ENTRIES),
    .IW     (IW),
    .CW     (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_item_size(in_item_size),
    .in_object_id(in_object_id),
    .res_vld     (res_vld),
    .res         (res),
    .out_free    (out_free),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  bfsc_mem #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_res_r.found;
  assign out_full_res    = out_res_r.full_res;
  assign out_result_id   = out_res_r.result_id;
  assign out_result_size = out_res_r.result_size;

endmodule

### tb/best_fit_size_cache_unit_tb.sv
// testbench for best_fit_size_cache_unit: directed and random beats checked against a shadow store
module best_fit_size_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 32;
  localparam int SIZE_W = bfsc_pkg::SIZE_W;
  localparam int ID_W = bfsc_pkg::ID_W;
  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
  localparam int TAIL_CYCLES = 4 * ENTRIES;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = bfsc_pkg::KIND_INSERT;
  logic [SIZE_W-1:0] in_item_size = '0;
  logic [ID_W-1:0] in_object_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic out_full_res;
  logic [ID_W-1:0] out_result_id;
  logic [SIZE_W-1:0] out_result_size;

  logic [SIZE_W-1:0] shadow_sizes [ENTRIES];
  logic [ID_W-1:0] shadow_ids [ENTRIES];
  int shadow_count = 0;
  bfsc_pkg::res_t pending_results [$];

  int err_count = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int sink_hold_req = 0;

  best_fit_size_cache_unit #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_item_size(in_item_size),
    .in_object_id(in_object_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_found(out_found),
    .out_full_res(out_full_res),
    .out_result_id(out_result_id),
    .out_result_size(out_result_size)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("best_fit_size_cache_unit_tb: FAIL");
    $finish;
  end

  // shadow of the sorted store, largest first
  function automatic bfsc_pkg::res_t apply_cache_op(logic kind, logic [SIZE_W-1:0] size,
                                                     logic [ID_W-1:0] id);
    bfsc_pkg::res_t r;
    int pos;
    int best;
    r = '0;
    if (kind == bfsc_pkg::KIND_INSERT) begin
      if (shadow_count >= ENTRIES) begin
        r.full_res = 1'b1;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_sizes[pos] >= size) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_sizes[i] = shadow_sizes[i-1];
          shadow_ids[i] = shadow_ids[i-1];
        end
        shadow_sizes[pos] = size;
        shadow_ids[pos] = id;
        shadow_count++;
        r.found = 1'b1;
      end
    end else begin
      pos = 0;
      while (pos < shadow_count && shadow_sizes[pos] >= size) pos++;
      if (pos != 0) begin
        best = pos - 1;
        r.found = 1'b1;
        r.result_id = shadow_ids[best];
        r.result_size = shadow_sizes[best];
        for (int i = best; i + 1 < shadow_count; i++) begin
          shadow_sizes[i] = shadow_sizes[i+1];
          shadow_ids[i] = shadow_ids[i+1];
        end
        shadow_count--;
      end
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(bit near_stored);
    logic [SIZE_W-1:0] s;
    logic [63:0] wide;
    int mode;
    mode = $urandom_range(0, 9);
    wide = {$urandom, $urandom};
    if (near_stored && shadow_count > 0 && mode < 5) begin
      s = shadow_sizes[$urandom_range(0, shadow_count - 1)];
      case ($urandom_range(0, 2))
        0: s = s - 1'b1;
        1: s = s + 1'b1;
        default: ;
      endcase
    end else if (mode < 6) begin
      s = SIZE_W'($urandom_range(0, 20));
    end else if (mode < 8) begin
      s = wide[SIZE_W-1:0];
    end else if (mode < 9) begin
      s = $urandom_range(0, 1) ? SIZE_MAX - SIZE_W'($urandom_range(0, 3)) : '0;
    end else begin
      s = SIZE_W'(wide[15:0]) << $urandom_range(0, 32);
    end
    return s;
  endfunction

  task automatic send_item(logic kind, logic [SIZE_W-1:0] size, logic [ID_W-1:0] id);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_item_size <= size;
    in_object_id <= id;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_cache_op(kind, size, id));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    bfsc_pkg::res_t exp_res;
    if (pending_results.size() == 0) begin
      $error("result beat with no expectation waiting");
      err_count++;
    end else begin
      exp_res = pending_results.pop_front();
      if (out_found !== exp_res.found) begin
        $error("found: expected %0h, actual %0h", exp_res.found, out_found);
        err_count++;
      end
      if (out_full_res !== exp_res.full_res) begin
        $error("full_res: expected %0h, actual %0h", exp_res.full_res, out_full_res);
        err_count++;
      end
      if (out_result_id !== exp_res.result_id) begin
        $error("result_id: expected %0h, actual %0h", exp_res.result_id, out_result_id);
        err_count++;
      end
      if (out_result_size !== exp_res.result_size) begin
        $error("result_size: expected %0h, actual %0h", exp_res.result_size, out_result_size);
        err_count++;
      end
    end
  endtask

  initial begin : result_sink
    int burst;
    int hold_left;
    burst = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result();
      if (sink_hold_req > 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    send_item(bfsc_pkg::KIND_FIT, '0, 32'h0000_0000);
    send_item(bfsc_pkg::KIND_FIT, SIZE_MAX, ID_MAX);
    send_item(bfsc_pkg::KIND_INSERT, '0, '0);
    send_item(bfsc_pkg::KIND_INSERT, SIZE_MAX, ID_MAX);
    send_item(bfsc_pkg::KIND_INSERT, 48'd100, 32'h8000_0001);
    send_item(bfsc_pkg::KIND_INSERT, 48'd100, 32'h5555_5555);
    send_item(bfsc_pkg::KIND_INSERT, 48'd100, 32'haaaa_aaaa);
    send_item(bfsc_pkg::KIND_FIT, SIZE_MAX, '0);
    send_item(bfsc_pkg::KIND_FIT, SIZE_MAX, ID_MAX);
    send_item(bfsc_pkg::KIND_FIT, 48'd100, '0);
    send_item(bfsc_pkg::KIND_FIT, 48'd1, '0);
    send_item(bfsc_pkg::KIND_FIT, '0, '0);
    send_item(bfsc_pkg::KIND_FIT, '0, '0);
    send_item(bfsc_pkg::KIND_FIT, '0, '0);
    send_item(bfsc_pkg::KIND_INSERT, 48'd5, 32'd1);
    send_item(bfsc_pkg::KIND_INSERT, 48'd7, 32'd2);
    send_item(bfsc_pkg::KIND_INSERT, 48'd6, 32'd3);
    send_item(bfsc_pkg::KIND_FIT, 48'd6, '0);
    send_item(bfsc_pkg::KIND_FIT, 48'd6, '0);
    send_item(bfsc_pkg::KIND_FIT, 48'd6, '0);
    send_item(bfsc_pkg::KIND_FIT, 48'd5, '0);
  endtask

  task automatic test_full_store();
    while (shadow_count < ENTRIES)
      send_item(bfsc_pkg::KIND_INSERT, pick_size(1'b1), $urandom);
    repeat (3) send_item(bfsc_pkg::KIND_INSERT, pick_size(1'b0), $urandom);
    send_item(bfsc_pkg::KIND_FIT, pick_size(1'b1), $urandom);
    send_item(bfsc_pkg::KIND_INSERT, pick_size(1'b1), $urandom);
    send_item(bfsc_pkg::KIND_INSERT, SIZE_MAX, ID_MAX);
    while (shadow_count > 0)
      send_item(bfsc_pkg::KIND_FIT, $urandom_range(0, 3) == 0 ? pick_size(1'b1) : '0, $urandom);
  endtask

  task automatic test_random(int n, int insert_pct);
    logic kind;
    repeat (n) begin
      kind = ($urandom_range(0, 99) < insert_pct) ? bfsc_pkg::KIND_INSERT : bfsc_pkg::KIND_FIT;
      send_item(kind, pick_size(kind == bfsc_pkg::KIND_FIT), $urandom);
    end
  endtask

  task automatic test_backpressure();
    bit saved_idle;
    saved_idle = src_idle_en;
    src_idle_en = 1'b0;
    sink_hold_req = 20 * ENTRIES;
    test_random(60, 60);
    src_idle_en = saved_idle;
  endtask

  task automatic test_drain_pause();
    test_random(30, 50);
    wait_for_drain();
    test_random(30, 50);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_store();
    test_random(300, 70);
    test_backpressure();
    test_drain_pause();
    test_random(300, 30);
    test_random(300, 50);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random(150, 55);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("best_fit_size_cache_unit_tb: PASS");
    end else begin
      $display("best_fit_size_cache_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
